// File: rtl/geodetic_to_ecef_core_assert.svh
`ifndef GEODETIC_TO_ECEF_CORE_ASSERT_SVH
`define GEODETIC_TO_ECEF_CORE_ASSERT_SVH

// same-cycle implication
`define G2E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define G2E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/g2e_pkg.sv
package g2e_pkg;

	localparam int ROT_STAGES_DEF = 32;
	localparam int NEWTON_STEPS = 12;
	localparam int NEWTON_LAT = 6;
	localparam int MUL_LAT = 2;

	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;
	localparam logic [63:0] ONE_Q61 = 64'h2000_0000_0000_0000;
	localparam logic [63:0] THREE_Q61 = 64'h6000_0000_0000_0000;
	localparam logic [63:0] Y0_Q61 = 64'h3000_0000_0000_0000;
	localparam logic [63:0] NORM_LO = 64'h0800_0000_0000_0000;

	localparam logic [32:0] A_RST = 33'd6531212288;
	localparam logic [31:0] E2_RST = 32'd28752142;

	localparam logic CFG_SEMI_MAJOR = 1'b0;
	localparam logic CFG_ECC_SQ = 1'b1;

	localparam logic signed [63:0] OUT_MAX = 64'sd17179869183;
	localparam logic signed [63:0] OUT_MIN = -64'sd17179869184;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} rot_t;

	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> s);
	endfunction

	// long division for elaboration-time constants only
	function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic signed [63:0] atan_q62(input int i);
		logic signed [63:0] sum;
		logic [63:0] den;
		logic [63:0] term;
		int p;
		bit done;
		sum = '0;
		done = 1'b0;
		if (i == 0)
			return $signed(PI_Q62 >> 2);
		for (int k = 0; k < 64; k++) begin
			den = 64'(2 * k + 1);
			p = i * (2 * k + 1);
			if (p > 62)
				done = 1'b1;
			if (!done) begin
				term = udiv_const(64'd1 << (62 - p), den);
				sum = ((k & 1) != 0) ? sum - $signed(term) : sum + $signed(term);
			end
		end
		return sum;
	endfunction

	function automatic logic signed [63:0] cordic_gain(input int r);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] vy2;
		logic [63:0] t;
		int e;
		p = ONE_Q61;
		for (int i = 0; i < r; i++) begin
			if (i == 0)
				p = p << 1;
			else if (2 * i < 64)
				p = p + (p >> (2 * i));
		end
		v = p;
		e = 0;
		for (int n = 0; n < 32; n++) begin
			if (v > ONE_Q61) begin
				v = v >> 2;
				e = e - 1;
			end
		end
		for (int n = 0; n < 32; n++) begin
			if (v < (ONE_Q61 >> 2)) begin
				v = v << 2;
				e = e + 1;
			end
		end
		y = Y0_Q61;
		for (int n = 0; n < NEWTON_STEPS; n++) begin
			y2 = mul_shr(y, y, 61);
			vy2 = mul_shr(v, y2, 61);
			t = (vy2 < THREE_Q61) ? THREE_Q61 - vy2 : 64'd0;
			y = mul_shr(y, t, 62);
		end
		if (e < 0)
			y = y >> (-e);
		else
			y = y << e;
		return $signed(y);
	endfunction

	function automatic logic signed [34:0] to_output(input logic signed [63:0] q20);
		logic [63:0] mag;
		logic [63:0] m;
		logic signed [63:0] v;
		mag = q20[63] ? 64'(-q20) : 64'(q20);
		m = (mag + 64'd512) >> 10;
		v = q20[63] ? -$signed(m) : $signed(m);
		if (v > OUT_MAX)
			v = OUT_MAX;
		if (v < OUT_MIN)
			v = OUT_MIN;
		return v[34:0];
	endfunction

endpackage

// File: rtl/g2e_if.sv
interface g2e_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] latitude_angle;
	logic signed [31:0] longitude_angle;
	logic signed [31:0] height_above;

	modport source (output valid, latitude_angle, longitude_angle, height_above, input ready);
	modport sink (input valid, latitude_angle, longitude_angle, height_above, output ready);
endinterface

interface g2e_ecef_if;
	logic valid;
	logic ready;
	logic signed [34:0] axis_polar;
	logic signed [34:0] axis_meridian;
	logic signed [34:0] axis_east;

	modport source (output valid, axis_polar, axis_meridian, axis_east, input ready);
	modport sink (input valid, axis_polar, axis_meridian, axis_east, output ready);
endinterface

// File: rtl/g2e_dly.sv
module g2e_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < D; i++)
				sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[D-1];

endmodule

// File: rtl/g2e_mul.sv
module g2e_mul (
	input  logic          clk,
	input  logic          en,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	output logic [127:0]  p
);

	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [127:0] p_s2;

	// four 32x32 partial products, then one wide sum
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			hh_s1 <= a[63:32] * b[63:32];
			p_s2 <= {64'd0, ll_s1} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
				+ {hh_s1, 64'd0};
		end
	end

	assign p = p_s2;

endmodule

// File: rtl/g2e_cordic_cell.sv
module g2e_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          en,
	input  g2e_pkg::rot_t rot,
	output g2e_pkg::rot_t rot_next
);

	localparam logic signed [63:0] ANG = g2e_pkg::atan_q62(IDX);

	logic signed [63:0] x, y, z, dx, dy;
	g2e_pkg::rot_t rot_s1;

	always_comb begin
		x = rot.x;
		y = rot.y;
		z = rot.z;
		dx = y >>> IDX;
		dy = x >>> IDX;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z[63]) begin
				rot_s1.x <= x - dx;
				rot_s1.y <= y + dy;
				rot_s1.z <= z - ANG;
			end else begin
				rot_s1.x <= x + dx;
				rot_s1.y <= y - dy;
				rot_s1.z <= z + ANG;
			end
		end
	end

	assign rot_next = rot_s1;

endmodule

// File: rtl/g2e_newton_cell.sv
module g2e_newton_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	input  logic [63:0] y,
	output logic [63:0] v_next,
	output logic [63:0] y_next
);

	logic [127:0] yy_p, vy_p, yt_p;
	logic [63:0] y_d2, y_d4, y2, vy2, t;
	logic [63:0] v_d2;

	g2e_mul u_yy (.clk, .en, .a(y), .b(y), .p(yy_p));
	g2e_dly #(.W(64), .D(g2e_pkg::MUL_LAT)) u_y2 (.clk, .en, .d(y), .q(y_d2));

	assign y2 = yy_p[61 +: 64];

	g2e_mul u_vy (.clk, .en, .a(v_d2), .b(y2), .p(vy_p));
	g2e_dly #(.W(64), .D(g2e_pkg::MUL_LAT)) u_y4 (.clk, .en, .d(y_d2), .q(y_d4));

	g2e_dly #(.W(64), .D(g2e_pkg::MUL_LAT)) u_v2 (.clk, .en, .d(v), .q(v_d2));

	assign vy2 = vy_p[61 +: 64];
	assign t = (vy2 < g2e_pkg::THREE_Q61) ? g2e_pkg::THREE_Q61 - vy2 : 64'd0;

	g2e_mul u_yt (.clk, .en, .a(y_d4), .b(t), .p(yt_p));
	g2e_dly #(.W(64), .D(g2e_pkg::NEWTON_LAT - g2e_pkg::MUL_LAT)) u_v6 (
		.clk, .en, .d(v_d2), .q(v_next));

	assign y_next = yt_p[62 +: 64];

endmodule

// File: rtl/geodetic_to_ecef_core.sv
// channel   dir  payload                                       handshake
// point     in   latitude_angle, longitude_angle, height_above  valid/ready
// ecef      out  axis_polar, axis_meridian, axis_east            valid/ready
// cfg       in   cfg_index, cfg_data                             cfg_wr_en, no stall
//
// one point per cycle while ecef is not stalled; pipeline depth is set mainly by the two rotator
// cell rows and the twelve root refinement cells
// the whole pipeline advances together when the output register is empty or taken
// a stall at ecef holds every stage, including the input transfer
// arst_n clears the valid row and loads the ellipsoid registers with their defaults
module geodetic_to_ecef_core #(
	parameter int ROTATION_STAGES = g2e_pkg::ROT_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	g2e_point_if.sink         point,
	g2e_ecef_if.source        ecef,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [32:0]       cfg_data
);

	`include "geodetic_to_ecef_core_assert.svh"

	localparam int R = ROTATION_STAGES;
	localparam int S_Q = R + 4;
	localparam int S_V = S_Q + 5;
	localparam int S_Y = S_V + g2e_pkg::NEWTON_STEPS * g2e_pkg::NEWTON_LAT;
	localparam int S_N = S_Y + 3;
	localparam int S_C = S_N + 3;
	localparam int LAT = S_C + 4;
	localparam logic signed [63:0] GAIN = g2e_pkg::cordic_gain(R);

	logic [32:0] smaj_q;
	logic [31:0] e2_q;
	logic [LAT:1] vld_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smaj_q <= g2e_pkg::A_RST;
			e2_q <= g2e_pkg::E2_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				g2e_pkg::CFG_SEMI_MAJOR: smaj_q <= cfg_data;
				g2e_pkg::CFG_ECC_SQ: e2_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign en = !vld_q[LAT] || ecef.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-1:1], point.valid};
	end

	// quadrant reduction
	logic [31:0] lat_sum, lon_sum, lat_d, lon_d;
	logic [1:0] qlat_s1, qlon_s1;
	logic [29:0] rlat_s1, rlon_s1;
	logic [1:0] rneg_s1;
	logic [31:0] h_s1;

	assign lat_sum = point.latitude_angle + 32'h2000_0000;
	assign lon_sum = point.longitude_angle + 32'h2000_0000;
	assign lat_d = point.latitude_angle - {lat_sum[31:30], 30'd0};
	assign lon_d = point.longitude_angle - {lon_sum[31:30], 30'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			qlat_s1 <= lat_sum[31:30];
			qlon_s1 <= lon_sum[31:30];
			rlat_s1 <= lat_d[31] ? 30'(-lat_d) : lat_d[29:0];
			rlon_s1 <= lon_d[31] ? 30'(-lon_d) : lon_d[29:0];
			rneg_s1 <= {lat_d[31], lon_d[31]};
			h_s1 <= point.height_above;
		end
	end

	// residual to radians
	logic [127:0] zlat_p, zlon_p;
	logic [1:0] rneg_d;
	logic [63:0] zlat_m, zlon_m;

	g2e_mul u_zlat (.clk, .en, .a({34'd0, rlat_s1}), .b(g2e_pkg::PI_Q62), .p(zlat_p));
	g2e_mul u_zlon (.clk, .en, .a({34'd0, rlon_s1}), .b(g2e_pkg::PI_Q62), .p(zlon_p));
	g2e_dly #(.W(2), .D(2)) u_rneg (.clk, .en, .d(rneg_s1), .q(rneg_d));

	assign zlat_m = zlat_p[31 +: 64];
	assign zlon_m = zlon_p[31 +: 64];

	// rotator cell rows
	g2e_pkg::rot_t lat_rot [R+1];
	g2e_pkg::rot_t lon_rot [R+1];

	always_comb begin
		lat_rot[0].x = GAIN;
		lat_rot[0].y = '0;
		lat_rot[0].z = rneg_d[1] ? -$signed(zlat_m) : $signed(zlat_m);
		lon_rot[0].x = GAIN;
		lon_rot[0].y = '0;
		lon_rot[0].z = rneg_d[0] ? -$signed(zlon_m) : $signed(zlon_m);
	end

	for (genvar i = 0; i < R; i++) begin : g_rot
		g2e_cordic_cell #(.IDX(i)) u_lat (.clk, .en, .rot(lat_rot[i]), .rot_next(lat_rot[i+1]));
		g2e_cordic_cell #(.IDX(i)) u_lon (.clk, .en, .rot(lon_rot[i]), .rot_next(lon_rot[i+1]));
	end

	logic [3:0] q_d;
	g2e_dly #(.W(4), .D(R + 2)) u_q (.clk, .en, .d({qlat_s1, qlon_s1}), .q(q_d));

	// quadrant map
	logic signed [63:0] cb_s2, sb_s2, cl_s2, sl_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_d[3:2])
				2'd0: begin cb_s2 <= lat_rot[R].x; sb_s2 <= lat_rot[R].y; end
				2'd1: begin cb_s2 <= -lat_rot[R].y; sb_s2 <= lat_rot[R].x; end
				2'd2: begin cb_s2 <= -lat_rot[R].x; sb_s2 <= -lat_rot[R].y; end
				default: begin cb_s2 <= lat_rot[R].y; sb_s2 <= -lat_rot[R].x; end
			endcase
			case (q_d[1:0])
				2'd0: begin cl_s2 <= lon_rot[R].x; sl_s2 <= lon_rot[R].y; end
				2'd1: begin cl_s2 <= -lon_rot[R].y; sl_s2 <= lon_rot[R].x; end
				2'd2: begin cl_s2 <= -lon_rot[R].x; sl_s2 <= -lon_rot[R].y; end
				default: begin cl_s2 <= lon_rot[R].y; sl_s2 <= -lon_rot[R].x; end
			endcase
		end
	end

	// 1 - e2 sin^2 B
	logic [127:0] ss_p, es_p;
	logic [63:0] sb_mag, ss_raw, ss, w2, vn;
	logic [3:0] ex;
	logic [63:0] v_s3;
	logic [3:0] e_s3;

	assign sb_mag = sb_s2[63] ? 64'(-sb_s2) : 64'(sb_s2);
	g2e_mul u_ss (.clk, .en, .a(sb_mag), .b(sb_mag), .p(ss_p));
	assign ss_raw = ss_p[61 +: 64];
	assign ss = (ss_raw > g2e_pkg::ONE_Q61) ? g2e_pkg::ONE_Q61 : ss_raw;
	g2e_mul u_es (.clk, .en, .a({32'd0, e2_q}), .b(ss), .p(es_p));
	assign w2 = g2e_pkg::ONE_Q61 - es_p[32 +: 64];

	always_comb begin
		vn = w2;
		ex = '0;
		for (int j = 0; j < 4; j++) begin
			if (vn < (g2e_pkg::ONE_Q61 >> (16 >> j))) begin
				vn = vn << (16 >> j);
				ex = ex + 4'((16 >> j) >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3 <= vn;
			e_s3 <= ex;
		end
	end

	// reciprocal square root refinement
	logic [63:0] nv [g2e_pkg::NEWTON_STEPS+1];
	logic [63:0] ny [g2e_pkg::NEWTON_STEPS+1];

	assign nv[0] = v_s3;
	assign ny[0] = g2e_pkg::Y0_Q61;

	for (genvar n = 0; n < g2e_pkg::NEWTON_STEPS; n++) begin : g_nwt
		g2e_newton_cell u_nwt (.clk, .en, .v(nv[n]), .y(ny[n]), .v_next(nv[n+1]),
			.y_next(ny[n+1]));
	end

	// prime-vertical radius
	logic [127:0] ay_p;
	logic [3:0] e_d;
	logic [31:0] h_d;
	logic [5:0] nshift;
	logic [63:0] n20, h20;
	logic [63:0] n20_s4, nh20_s4, h20_s4;
	logic signed [63:0] cb_d;

	g2e_mul u_ay (.clk, .en, .a({31'd0, smaj_q}), .b(ny[g2e_pkg::NEWTON_STEPS]), .p(ay_p));
	g2e_dly #(.W(4), .D(S_Y + 2 - S_V)) u_e (.clk, .en, .d(e_s3), .q(e_d));
	g2e_dly #(.W(32), .D(S_Y + 1)) u_h (.clk, .en, .d(h_s1), .q(h_d));

	assign nshift = 6'd51 - {2'd0, e_d};
	assign n20 = 64'(ay_p >> nshift);
	assign h20 = {{22{h_d[31]}}, h_d, 10'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			n20_s4 <= n20;
			nh20_s4 <= n20 + h20;
			h20_s4 <= h20;
		end
	end

	g2e_dly #(.W(64), .D(S_N - S_Q)) u_cb (.clk, .en, .d(cb_s2), .q(cb_d));

	// (N + H) cos B and N (1 - e2) + H
	logic [127:0] pm_p, cm_p;
	logic [63:0] nh_mag, cb_mag, h20_d, cm;
	logic negc_d;
	logic [63:0] p20_s5, c20_s5;

	assign nh_mag = nh20_s4[63] ? 64'(-nh20_s4) : nh20_s4;
	assign cb_mag = cb_d[63] ? 64'(-cb_d) : 64'(cb_d);

	g2e_mul u_pm (.clk, .en, .a(n20_s4),
		.b({31'd0, 33'h1_0000_0000 - {1'b0, e2_q}}), .p(pm_p));
	g2e_mul u_cm (.clk, .en, .a(nh_mag), .b(cb_mag), .p(cm_p));
	g2e_dly #(.W(1), .D(2)) u_negc (.clk, .en, .d(nh20_s4[63] ^ cb_d[63]), .q(negc_d));
	g2e_dly #(.W(64), .D(2)) u_h20 (.clk, .en, .d(h20_s4), .q(h20_d));

	assign cm = cm_p[61 +: 64];

	always_ff @(posedge clk) begin
		if (en) begin
			p20_s5 <= pm_p[32 +: 64] + h20_d;
			c20_s5 <= negc_d ? 64'(-cm) : cm;
		end
	end

	// final rotations
	logic signed [63:0] sb_d, cl_d, sl_d;
	logic [127:0] op_p, om_p, oe_p;
	logic [63:0] p_mag, c_mag, sbd_mag, cl_mag, sl_mag;
	logic [2:0] neg_d;
	logic [63:0] rp, rm, re;
	logic signed [63:0] res_p_s6, res_m_s6, res_e_s6;

	g2e_dly #(.W(64), .D(S_C - S_Q)) u_sb (.clk, .en, .d(sb_s2), .q(sb_d));
	g2e_dly #(.W(64), .D(S_C - S_Q)) u_cl (.clk, .en, .d(cl_s2), .q(cl_d));
	g2e_dly #(.W(64), .D(S_C - S_Q)) u_sl (.clk, .en, .d(sl_s2), .q(sl_d));

	assign p_mag = p20_s5[63] ? 64'(-p20_s5) : p20_s5;
	assign c_mag = c20_s5[63] ? 64'(-c20_s5) : c20_s5;
	assign sbd_mag = sb_d[63] ? 64'(-sb_d) : 64'(sb_d);
	assign cl_mag = cl_d[63] ? 64'(-cl_d) : 64'(cl_d);
	assign sl_mag = sl_d[63] ? 64'(-sl_d) : 64'(sl_d);

	g2e_mul u_op (.clk, .en, .a(p_mag), .b(sbd_mag), .p(op_p));
	g2e_mul u_om (.clk, .en, .a(c_mag), .b(cl_mag), .p(om_p));
	g2e_mul u_oe (.clk, .en, .a(c_mag), .b(sl_mag), .p(oe_p));
	g2e_dly #(.W(3), .D(2)) u_neg (.clk, .en,
		.d({p20_s5[63] ^ sb_d[63], c20_s5[63] ^ cl_d[63], c20_s5[63] ^ sl_d[63]}),
		.q(neg_d));

	assign rp = op_p[61 +: 64];
	assign rm = om_p[61 +: 64];
	assign re = oe_p[61 +: 64];

	always_ff @(posedge clk) begin
		if (en) begin
			res_p_s6 <= neg_d[2] ? -$signed(rp) : $signed(rp);
			res_m_s6 <= neg_d[1] ? -$signed(rm) : $signed(rm);
			res_e_s6 <= neg_d[0] ? -$signed(re) : $signed(re);
		end
	end

	// rounding and saturation into the output register
	logic signed [34:0] out_p_s7, out_m_s7, out_e_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			out_p_s7 <= g2e_pkg::to_output(res_p_s6);
			out_m_s7 <= g2e_pkg::to_output(res_m_s6);
			out_e_s7 <= g2e_pkg::to_output(res_e_s6);
		end
	end

	assign ecef.valid = vld_q[LAT];
	assign ecef.axis_polar = out_p_s7;
	assign ecef.axis_meridian = out_m_s7;
	assign ecef.axis_east = out_e_s7;

	`G2E_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "pipeline moved during output stall")
	`G2E_ASSERT_NEXT(a_enter, point.valid && en, vld_q[1], "accepted point not in pipeline")
	`G2E_ASSERT_NOW(a_norm, vld_q[S_V], (v_s3 >= g2e_pkg::NORM_LO) && (v_s3 <= g2e_pkg::ONE_Q61), "root input out of range")

endmodule

// File: tb/sv/geodetic_to_ecef_checker.sv
module geodetic_to_ecef_checker (
	input  logic        clk,
	input  logic        arst_n,
	g2e_point_if        point,
	g2e_ecef_if         ecef,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [32:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = g2e_pkg::ROT_STAGES_DEF;
	localparam logic [63:0] UNIT_Q61 = 64'h2000_0000_0000_0000;
	localparam logic [63:0] PI_BITS = 64'hC90F_DAA2_2168_C234;

	typedef struct {
		logic signed [34:0] polar;
		logic signed [34:0] meridian;
		logic signed [34:0] east;
	} ecef_point_t;

	ecef_point_t ecef_expected_q[$];
	logic [32:0] axis_a;
	logic [31:0] ecc_sq;
	longint atan_tab [STAGES];
	longint rot_gain;

	function automatic logic [63:0] prod_shr(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint sprod_shr(longint a, longint b, int s);
		longint r;
		r = longint'(prod_shr(mag64(a), mag64(b), s));
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint arctan_pow2(int i);
		longint acc;
		logic [63:0] den;
		int p;
		acc = 0;
		if (i == 0)
			return longint'(PI_BITS >> 2);
		for (int k = 0; k < 64; k++) begin
			den = 64'(2 * k + 1);
			p = i * (2 * k + 1);
			if (p > 62)
				break;
			if (k % 2 == 1)
				acc -= longint'((64'd1 << (62 - p)) / den);
			else
				acc += longint'((64'd1 << (62 - p)) / den);
		end
		return acc;
	endfunction

	function automatic logic [63:0] inv_root(logic [63:0] v, output int k);
		logic [63:0] y, y2, vy2, t;
		int e;
		y = 64'h3000_0000_0000_0000;
		e = 0;
		if (v == 0)
			v = 1;
		while (v > UNIT_Q61) begin
			v = v >> 2;
			e--;
		end
		while (v < (UNIT_Q61 >> 2)) begin
			v = v << 2;
			e++;
		end
		for (int n = 0; n < 12; n++) begin
			y2 = prod_shr(y, y, 61);
			vy2 = prod_shr(v, y2, 61);
			t = (vy2 < 3 * UNIT_Q61) ? 3 * UNIT_Q61 - vy2 : 64'd0;
			y = prod_shr(y, t, 62);
		end
		k = e;
		return y;
	endfunction

	function automatic void rotate(logic [31:0] th, output longint c, output longint s);
		logic [31:0] q, d;
		longint r, x, y, z, dx, dy;
		q = ((th + 32'h2000_0000) >> 30) & 32'd3;
		d = th - (q << 30);
		r = longint'($signed(d));
		z = longint'(prod_shr(mag64(r), PI_BITS, 31));
		if (r < 0)
			z = -z;
		x = rot_gain;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		case (q)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic signed [34:0] round_sat(longint q20);
		logic [63:0] m;
		longint v;
		m = (mag64(q20) + 64'd512) >> 10;
		v = q20 < 0 ? -longint'(m) : longint'(m);
		if (v > 64'sd17179869183)
			v = 64'sd17179869183;
		if (v < -64'sd17179869184)
			v = -64'sd17179869184;
		return v[34:0];
	endfunction

	function automatic ecef_point_t convert(logic [31:0] lat, logic [31:0] lon,
		logic signed [31:0] h);
		ecef_point_t o;
		longint cb, sb, cl, sl, h20, p20, nh20, c20;
		logic [63:0] ss, w2, inv_w, n20;
		int k;
		rotate(lat, cb, sb);
		rotate(lon, cl, sl);
		ss = prod_shr(mag64(sb), mag64(sb), 61);
		if (ss > UNIT_Q61)
			ss = UNIT_Q61;
		w2 = UNIT_Q61 - prod_shr({32'd0, ecc_sq}, ss, 32);
		inv_w = inv_root(w2, k);
		n20 = prod_shr({31'd0, axis_a}, inv_w, 51 - k);
		h20 = longint'(h) * 1024;
		p20 = longint'(prod_shr(n20, (64'd1 << 32) - {32'd0, ecc_sq}, 32)) + h20;
		nh20 = longint'(n20) + h20;
		c20 = sprod_shr(nh20, cb, 61);
		o.polar = round_sat(sprod_shr(p20, sb, 61));
		o.meridian = round_sat(sprod_shr(c20, cl, 61));
		o.east = round_sat(sprod_shr(c20, sl, 61));
		return o;
	endfunction

	function automatic longint gain_of_row();
		logic [63:0] p, y;
		int k;
		p = UNIT_Q61;
		for (int i = 0; i < STAGES; i++) begin
			if (i == 0)
				p = p << 1;
			else if (2 * i < 64)
				p = p + (p >> (2 * i));
		end
		y = inv_root(p, k);
		y = k < 0 ? y >> (-k) : y << k;
		return longint'(y);
	endfunction

	task automatic report(string what, logic signed [34:0] got, logic signed [34:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < STAGES; i++)
			atan_tab[i] = arctan_pow2(i);
		rot_gain = gain_of_row();
	end

	assign pending = ecef_expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ecef_point_t want;
		if (!arst_n) begin
			axis_a <= g2e_pkg::A_RST;
			ecc_sq <= g2e_pkg::E2_RST;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == g2e_pkg::CFG_SEMI_MAJOR)
					axis_a <= cfg_data;
				else
					ecc_sq <= cfg_data[31:0];
			end
			if (point.valid && point.ready)
				ecef_expected_q.push_back(convert(point.latitude_angle,
					point.longitude_angle, point.height_above));
			if (ecef.valid && ecef.ready) begin
				if (ecef_expected_q.size() == 0) begin
					$display("unexpected ecef transfer at %0t", $realtime);
					errors++;
				end else begin
					want = ecef_expected_q.pop_front();
					if (ecef.axis_polar !== want.polar)
						report("axis_polar", ecef.axis_polar, want.polar);
					if (ecef.axis_meridian !== want.meridian)
						report("axis_meridian", ecef.axis_meridian, want.meridian);
					if (ecef.axis_east !== want.east)
						report("axis_east", ecef.axis_east, want.east);
				end
			end
		end
	end
endmodule

// File: tb/sv/geodetic_to_ecef_core_tb.sv
module geodetic_to_ecef_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = g2e_pkg::CFG_SEMI_MAJOR;
	logic [32:0] cfg_data = '0;
	int errors;
	int pending;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_tick = 0;

	g2e_point_if point ();
	g2e_ecef_if ecef ();

	geodetic_to_ecef_core dut (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .ecef(ecef.source),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	geodetic_to_ecef_checker checker_i (
		.clk(clk), .arst_n(arst_n), .point(point), .ecef(ecef),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		point.valid = 1'b0;
		point.latitude_angle = '0;
		point.longitude_angle = '0;
		point.height_above = '0;
		ecef.ready = 1'b0;
	end

	// receiver stall pattern steps through four ready modes
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		case ((stall_tick >> 7) % 4)
			0: ecef.ready <= 1'b1;
			1: ecef.ready <= ($urandom_range(1, 0) == 1);
			2: ecef.ready <= ($urandom_range(7, 0) == 0);
			default: ecef.ready <= ($urandom_range(7, 0) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((point.valid && point.ready) || (ecef.valid && ecef.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_point(longint lat, longint lon, longint h);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				point.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(40, 1);
		end
		point.valid <= 1'b1;
		point.latitude_angle <= 32'(lat);
		point.longitude_angle <= 32'(lon);
		point.height_above <= 32'(h);
		do
			@(posedge clk);
		while (!point.ready);
		burst_left--;
	endtask

	task automatic set_ellipsoid(logic [32:0] a, logic [31:0] e2);
		point.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= g2e_pkg::CFG_SEMI_MAJOR;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= g2e_pkg::CFG_ECC_SQ;
		cfg_data <= {1'b0, e2};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_points(int count);
		longint lat, lon, h;
		for (int i = 0; i < count; i++) begin
			lat = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
			if ($urandom_range(9, 0) == 0)
				lat = $urandom_range(1, 0) ? 64'sd1073741824 : -64'sd1073741824;
			lon = longint'($signed($urandom()));
			if ($urandom_range(3, 0) == 0)
				h = longint'($signed($urandom()));
			else
				h = longint'($urandom_range(20000000, 0)) - 64'sd1000000;
			send_point(lat, lon, h);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed points on the default ellipsoid
		send_point(0, 0, 0);
		send_point(64'sd1073741824, 0, 0);
		send_point(-64'sd1073741824, 0, 0);
		send_point(0, 64'sd1073741824, 0);
		send_point(0, -64'sd2147483648, 0);
		send_point(0, 64'sd2147483647, 0);
		send_point(0, -64'sd1073741824, 0);
		send_point(64'sd536870912, 64'sd536870912, 0);
		send_point(-64'sd536870912, -64'sd536870911, 0);
		send_point(64'sd536870911, 64'sd1610612736, 64'sd2147483647);
		send_point(-64'sd536870913, 64'sd2684354560, -64'sd2147483648);
		send_point(64'sd1073741823, 64'sd12345, 64'sd9000000);
		send_point(-64'sd1, -64'sd1, -64'sd1);
		send_point(64'sd1, 64'sd1, 64'sd1);
		random_points(150);
		// Krasovsky ellipsoid
		set_ellipsoid(33'd6531322880, 32'd28748026);
		random_points(150);
		// degenerate axis: only the height is rotated
		set_ellipsoid(33'd0, 32'd0);
		send_point(64'sd1073741824, 0, 64'sd2147483647);
		send_point(64'sd357913941, 64'sd715827882, -64'sd2147483648);
		random_points(100);
		// largest axis and eccentricity push outputs into saturation
		set_ellipsoid(33'h1_FFFF_FFFF, 32'hFFFF_FFFF);
		send_point(0, 0, 64'sd2147483647);
		send_point(64'sd1073741824, 0, 64'sd2147483647);
		send_point(-64'sd1073741824, 64'sd1073741824, -64'sd2147483648);
		random_points(150);
		set_ellipsoid(33'(longint'($urandom()) * 2 + $urandom_range(1, 0)), $urandom());
		random_points(120);
		set_ellipsoid(g2e_pkg::A_RST, g2e_pkg::E2_RST);
		random_points(130);
		point.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// File: geodetic_to_ecef_core.f
+incdir+rtl
rtl/g2e_pkg.sv
rtl/g2e_if.sv
rtl/g2e_dly.sv
rtl/g2e_mul.sv
rtl/g2e_cordic_cell.sv
rtl/g2e_newton_cell.sv
rtl/geodetic_to_ecef_core.sv
tb/sv/geodetic_to_ecef_checker.sv
tb/sv/geodetic_to_ecef_core_tb.sv
